/* design/dsrg_pkg.sv */
`default_nettype none
package dsrg_pkg;

  localparam logic [7:0]  ANGLE_MAX   = 8'd180;
  localparam logic [7:0]  RESET_ANGLE = 8'd90;
  localparam logic [7:0]  RESET_DELAY = 8'd13;
  localparam logic [7:0]  PULSE_BASE  = 8'd50;
  // pulse = 50 + floor(angle * 11111 / 10000); the /10000 is a multiply by
  // ceil(2^32 / 10000), exact for every angle from 0 to 180.
  localparam logic [13:0] SCALE_NUM   = 14'd11111;
  localparam logic [18:0] SCALE_RECIP = 19'd429497;
  localparam int          SCALE_SHIFT = 32;
  localparam int          NUM_LANES   = 2;

  typedef struct packed {
    logic [7:0] last;
    logic       neg;
    logic [7:0] mag;
  } lane_t;

  typedef struct packed {
    lane_t [NUM_LANES-1:0] lane;
  } cmd_t;

endpackage
`default_nettype wire

/* design/dual_servo_ramp_generator.sv */
// With the back end idle, an accepted request passes through the queue and the IDLE, DIV, ANG,
// SCL and PUL states before the first pulse request is valid; PUL waits out any output stall.
// Each step runs the back-end sequencer (divide, angle, scale, pulse, hold), the hold set by
// step_delay_ms and TICKS_PER_MS; a run is STEPS steps, then the sequencer returns to idle.
// A two-entry command queue holds the running ramp's request and one more behind it.
// Reset (synchronous, rst_n low): last angles 90, step delay 13, queue and output empty.
`default_nettype none
module dual_servo_ramp_generator #(
  parameter int STEPS        = 16,
  parameter int TICKS_PER_MS = 1
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [7:0] cfg_step_delay_ms,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_target_a,
  input  wire logic [7:0] in_target_b,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_pulse_a,
  output logic [7:0]      out_pulse_b,
  output logic            out_final_step
);
  import dsrg_pkg::*;

  cmd_t push_data;
  cmd_t pop_data;
  logic push, pop, full, empty;

  dsrg_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_target_a (in_target_a),
    .in_target_b (in_target_b),
    .q_full      (full),
    .q_push      (push),
    .q_push_data (push_data)
  );

  dsrg_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  dsrg_back #(
    .STEPS        (STEPS),
    .TICKS_PER_MS (TICKS_PER_MS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_step_delay_ms (cfg_step_delay_ms),
    .q_data            (pop_data),
    .q_empty           (empty),
    .q_pop             (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_pulse_a       (out_pulse_a),
    .out_pulse_b       (out_pulse_b),
    .out_final_step    (out_final_step)
  );

endmodule
`default_nettype wire

/* design/dsrg_front.sv */
`default_nettype none
module dsrg_front (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire logic [7:0]   in_target_a,
  input  wire logic [7:0]   in_target_b,
  input  wire logic         q_full,
  output logic              q_push,
  output dsrg_pkg::cmd_t    q_push_data
);
  import dsrg_pkg::*;

  logic [7:0] prev_r   [NUM_LANES];
  logic [7:0] prev_nxt [NUM_LANES];
  logic [7:0] tgt      [NUM_LANES];

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    tgt[0] = (in_target_a > ANGLE_MAX) ? ANGLE_MAX : in_target_a;
    tgt[1] = (in_target_b > ANGLE_MAX) ? ANGLE_MAX : in_target_b;
    for (int k = 0; k < NUM_LANES; k++) begin
      q_push_data.lane[k].last = prev_r[k];
      q_push_data.lane[k].neg  = tgt[k] < prev_r[k];
      q_push_data.lane[k].mag  = (tgt[k] < prev_r[k]) ? (prev_r[k] - tgt[k])
                                                      : (tgt[k] - prev_r[k]);
      prev_nxt[k] = q_push ? tgt[k] : prev_r[k];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NUM_LANES; k++) begin
      if (!rst_n) begin
        prev_r[k] <= RESET_ANGLE;
      end else begin
        prev_r[k] <= prev_nxt[k];
      end
    end
  end

endmodule
`default_nettype wire

/* design/dsrg_queue.sv */
`default_nettype none
module dsrg_queue (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  dsrg_pkg::cmd_t  push_data,
  output logic            full,
  input  wire logic       pop,
  output dsrg_pkg::cmd_t  pop_data,
  output logic            empty
);
  import dsrg_pkg::*;

  cmd_t       mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full     = cnt_r == 2'd2;
  assign empty    = cnt_r == 2'd0;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

/* design/dsrg_back.sv */
`default_nettype none
module dsrg_back #(
  parameter int STEPS        = 16,
  parameter int TICKS_PER_MS = 1
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_step_delay_ms,
  input  dsrg_pkg::cmd_t   q_data,
  input  wire logic        q_empty,
  output logic             q_pop,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_pulse_a,
  output logic [7:0]       out_pulse_b,
  output logic             out_final_step
);
  import dsrg_pkg::*;

  localparam int IW    = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam int PW    = 8 + IW;
  localparam int DIV_K = 24;
  localparam int DPW   = PW + 25;
  localparam int HW    = 8 + $clog2(TICKS_PER_MS + 1);
  localparam logic [24:0]   DivRecip = 25'(((64'd1 << DIV_K) + STEPS - 1) / STEPS);
  localparam logic [IW-1:0] LastIdx  = IW'(STEPS - 1);
  localparam logic [HW-1:0] Ticks    = HW'(TICKS_PER_MS);

  typedef enum logic [2:0] {
    ST_IDLE, ST_DIV, ST_ANG, ST_SCL, ST_PUL, ST_WAIT
  } state_t;

  state_t          state_r, state_nxt;
  logic [7:0]      delay_r, delay_nxt;
  logic [HW-1:0]   hold_r, hold_nxt;
  logic [IW-1:0]   idx_r, idx_nxt;
  logic            more_r, more_nxt;
  logic            ovalid_r, ovalid_nxt;
  logic            ofinal_r, ofinal_nxt;
  logic [7:0]      opulse_r   [NUM_LANES];
  logic [7:0]      opulse_nxt [NUM_LANES];
  logic [PW-1:0]   prod_r     [NUM_LANES];
  logic [PW-1:0]   prod_nxt   [NUM_LANES];
  logic [7:0]      quo_r      [NUM_LANES];
  logic [7:0]      quo_nxt    [NUM_LANES];
  logic [7:0]      ang_r      [NUM_LANES];
  logic [7:0]      ang_nxt    [NUM_LANES];
  logic [20:0]     scl_r      [NUM_LANES];
  logic [20:0]     scl_nxt    [NUM_LANES];
  logic [DPW-1:0]  dprod      [NUM_LANES];
  logic [20:0]     sprod      [NUM_LANES];
  logic [39:0]     rprod      [NUM_LANES];
  logic            out_free;

  assign cfg_ready      = 1'b1;
  assign out_valid      = ovalid_r;
  assign out_pulse_a    = opulse_r[0];
  assign out_pulse_b    = opulse_r[1];
  assign out_final_step = ofinal_r;
  assign out_free       = !ovalid_r || !out_stall;

  always_comb begin
    state_nxt  = state_r;
    delay_nxt  = (cfg_valid && cfg_ready) ? cfg_step_delay_ms : delay_r;
    hold_nxt   = hold_r;
    idx_nxt    = idx_r;
    more_nxt   = more_r;
    ovalid_nxt = (ovalid_r && !out_stall) ? 1'b0 : ovalid_r;
    ofinal_nxt = ofinal_r;
    q_pop      = 1'b0;
    for (int k = 0; k < NUM_LANES; k++) begin
      dprod[k]      = DPW'(prod_r[k]) * DPW'(DivRecip);
      sprod[k]      = 21'(ang_r[k]) * 21'(SCALE_NUM);
      rprod[k]      = 40'(scl_r[k]) * 40'(SCALE_RECIP);
      prod_nxt[k]   = prod_r[k];
      quo_nxt[k]    = quo_r[k];
      ang_nxt[k]    = ang_r[k];
      scl_nxt[k]    = scl_r[k];
      opulse_nxt[k] = opulse_r[k];
    end

    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          idx_nxt = '0;
          for (int k = 0; k < NUM_LANES; k++) begin
            prod_nxt[k] = '0;
          end
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        for (int k = 0; k < NUM_LANES; k++) begin
          quo_nxt[k] = dprod[k][DIV_K+7:DIV_K];
        end
        state_nxt = ST_ANG;
      end
      ST_ANG: begin
        for (int k = 0; k < NUM_LANES; k++) begin
          ang_nxt[k] = q_data.lane[k].neg ? (q_data.lane[k].last - quo_r[k])
                                          : (q_data.lane[k].last + quo_r[k]);
        end
        state_nxt = ST_SCL;
      end
      ST_SCL: begin
        for (int k = 0; k < NUM_LANES; k++) begin
          scl_nxt[k] = sprod[k];
        end
        state_nxt = ST_PUL;
      end
      ST_PUL: begin
        if (out_free) begin
          for (int k = 0; k < NUM_LANES; k++) begin
            opulse_nxt[k] = PULSE_BASE + 8'(rprod[k][SCALE_SHIFT+7:SCALE_SHIFT]);
            prod_nxt[k]   = prod_r[k] + PW'(q_data.lane[k].mag);
          end
          ovalid_nxt = 1'b1;
          ofinal_nxt = idx_r == LastIdx;
          more_nxt   = idx_r != LastIdx;
          q_pop      = idx_r == LastIdx;
          idx_nxt    = idx_r + 1'b1;
          hold_nxt   = HW'(delay_r) * Ticks;
          state_nxt  = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (hold_r != '0) begin
          hold_nxt = hold_r - 1'b1;
        end else begin
          state_nxt = more_r ? ST_DIV : ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    more_r   <= more_nxt;
    ofinal_r <= ofinal_nxt;
    for (int k = 0; k < NUM_LANES; k++) begin
      prod_r[k]   <= prod_nxt[k];
      quo_r[k]    <= quo_nxt[k];
      ang_r[k]    <= ang_nxt[k];
      scl_r[k]    <= scl_nxt[k];
      opulse_r[k] <= opulse_nxt[k];
    end
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      delay_r  <= RESET_DELAY;
      hold_r   <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      delay_r  <= delay_nxt;
      hold_r   <= hold_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

endmodule
`default_nettype wire
